>>> sv/fsc_pkg.sv
// Shared types, constants and signature helpers for the file signature classifier.
package fsc_pkg;

  localparam int unsigned DEF_POSITION_BITS = 32;

  localparam int unsigned PDF_WIN_BITS  = 16;
  localparam int unsigned TAIL_WIN_BITS = 20;
  localparam int unsigned CFG_ADDR_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 20;

  localparam logic [PDF_WIN_BITS-1:0]  PDF_WIN_RESET  = 16'd1024;
  localparam logic [TAIL_WIN_BITS-1:0] TAIL_WIN_RESET = 20'd8192;

  localparam logic [CFG_ADDR_BITS-1:0] REG_PDF_SEARCH_WINDOW   = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ENCRYPT_TAIL_WINDOW = 1'd1;

  localparam int unsigned HDR_DEPTH  = 12;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned OUT_TDATA_BITS = 40;

  localparam logic [2:0] PDF_WORD_LEN  = 3'd5;
  localparam logic [2:0] ENC_WORD_LAST = 3'd7;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_PDF     = 3'd1,
    KIND_JPEG    = 3'd2,
    KIND_PNG     = 3'd3,
    KIND_TIFF    = 3'd4,
    KIND_HEIF    = 3'd5,
    KIND_WEBP    = 3'd6
  } fsc_kind_t;

  typedef logic [7:0] fsc_byte_t;

  // Characters of "%PDF-" by position.
  function automatic fsc_byte_t pdf_char(input logic [2:0] pos);
    fsc_byte_t c;
    case (pos)
      3'd0:    c = 8'h25;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h46;
      3'd4:    c = 8'h2D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of "/Encrypt" by position.
  function automatic fsc_byte_t enc_char(input logic [2:0] pos);
    fsc_byte_t c;
    case (pos)
      3'd0:    c = 8'h2F;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h6E;
      3'd3:    c = 8'h63;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h79;
      3'd6:    c = 8'h70;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // True when the four bytes form one of the recognized HEIF brands.
  function automatic logic is_heif_brand(input logic [31:0] b);
    logic hit;
    case (b)
      {8'h68, 8'h65, 8'h69, 8'h63},
      {8'h68, 8'h65, 8'h69, 8'h78},
      {8'h68, 8'h65, 8'h69, 8'h6D},
      {8'h68, 8'h65, 8'h69, 8'h73},
      {8'h68, 8'h65, 8'h76, 8'h63},
      {8'h68, 8'h65, 8'h76, 8'h6D},
      {8'h68, 8'h65, 8'h76, 8'h73},
      {8'h6D, 8'h69, 8'h66, 8'h31},
      {8'h6D, 8'h73, 8'h66, 8'h31},
      {8'h61, 8'h76, 8'h69, 8'h66},
      {8'h61, 8'h76, 8'h69, 8'h73}: hit = 1'b1;
      default:                      hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> sv/file_signature_classifier_core.sv
// Top level of the file signature classifier: byte stream in, one classification per file out.
//
//  Channel  Direction  Transaction payload
//  in_      slave      tdata[7:0] data_byte, tlast last_byte
//  out_     master     tdata[2:0] file_kind, [3] encrypted_pdf, [35:4] byte_count, rest zero
//  cfg_     write      addr 0 pdf_search_window, addr 1 encrypt_tail_window
//
//  One byte is accepted per cycle while in_tready is high; each byte is held in the input
//  register and updates the scan state from there; a file's last byte loads the result register.
//  Only a last byte waits on a full result register, so out_tready low stalls input
//  only when a second file ends before the first result is taken.
//  Reset restores the default windows and starts a new file.
module file_signature_classifier_core
  import fsc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [2:0] file_kind, [3] encrypted_pdf,
                                                // [35:4] byte_count
  input  logic                      cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned WW = (PB > PDF_WIN_BITS) ? PB : PDF_WIN_BITS;
  localparam int unsigned SW = ((PB > TAIL_WIN_BITS) ? PB : TAIL_WIN_BITS) + 1;
  localparam int unsigned CW = (PB > COUNT_BITS) ? PB : COUNT_BITS;
  localparam int unsigned HI = $clog2(HDR_DEPTH);

  logic [PDF_WIN_BITS-1:0]  pdf_win_r;
  logic [TAIL_WIN_BITS-1:0] tail_win_r;

  logic      s1_valid_r;
  fsc_byte_t s1_byte_r;
  logic      s1_last_r;
  logic      s1_go;

  fsc_byte_t      hdr_r [HDR_DEPTH];
  fsc_byte_t      hdr_nxt [HDR_DEPTH];
  logic [PB-1:0]  pos_r, pos_nxt;
  logic [2:0]     pdf_prog_r, pdf_prog_nxt;
  logic           pdf_seen_r, pdf_seen_nxt;
  logic [2:0]     kw_prog_r, kw_prog_nxt;
  logic           kw_seen_r, kw_seen_nxt;
  logic [PB-1:0]  kw_start_r, kw_start_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_BITS-1:0] out_data_r;

  fsc_kind_t         kind;
  logic              enc;
  logic [COUNT_BITS-1:0] count;
  logic [WW-1:0]     n_w;
  logic [SW-1:0]     ls_w, n_s, lo_sum, hi_sum;
  logic [CW-1:0]     n_c;
  logic              jpeg_m, png_m, tiff_m, heif_m, webp_m;

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (pos_r < PB'(HDR_DEPTH)) begin
      hdr_nxt[pos_r[HI-1:0]] = s1_byte_r;
    end
    pos_nxt = (pos_r != '1) ? pos_r + PB'(1) : pos_r;
    n_w     = WW'(pos_nxt);

    pdf_seen_nxt = pdf_seen_r;
    if (s1_byte_r == pdf_char(pdf_prog_r) && pdf_prog_r < PDF_WORD_LEN) begin
      pdf_prog_nxt = pdf_prog_r + 3'd1;
      if (pdf_prog_nxt == PDF_WORD_LEN) begin
        if (n_w <= WW'(pdf_win_r) || pos_nxt == PB'(5)) begin
          pdf_seen_nxt = 1'b1;
        end
        pdf_prog_nxt = 3'd0;
      end
    end else begin
      pdf_prog_nxt = (s1_byte_r == pdf_char(3'd0)) ? 3'd1 : 3'd0;
    end

    kw_seen_nxt  = kw_seen_r;
    kw_start_nxt = kw_start_r;
    if (s1_byte_r == enc_char(kw_prog_r)) begin
      if (kw_prog_r == ENC_WORD_LAST) begin
        kw_seen_nxt  = 1'b1;
        kw_start_nxt = (pos_r >= PB'(7)) ? pos_r - PB'(7) : '0;
        kw_prog_nxt  = 3'd0;
      end else begin
        kw_prog_nxt = kw_prog_r + 3'd1;
      end
    end else begin
      kw_prog_nxt = (s1_byte_r == enc_char(3'd0)) ? 3'd1 : 3'd0;
    end
  end

  always_comb begin
    jpeg_m = pos_nxt >= PB'(3) && hdr_nxt[0] == 8'hFF && hdr_nxt[1] == 8'hD8
             && hdr_nxt[2] == 8'hFF;
    png_m  = pos_nxt >= PB'(8)
             && {hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]} == 32'h89504E47
             && {hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7]} == 32'h0D0A1A0A;
    tiff_m = pos_nxt >= PB'(4)
             && ({hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]} == 32'h49492A00
              || {hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]} == 32'h4D4D002A);
    heif_m = pos_nxt >= PB'(12)
             && {hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7]} == 32'h66747970
             && is_heif_brand({hdr_nxt[8], hdr_nxt[9], hdr_nxt[10], hdr_nxt[11]});
    webp_m = pos_nxt >= PB'(12)
             && {hdr_nxt[0], hdr_nxt[1], hdr_nxt[2], hdr_nxt[3]} == 32'h52494646
             && {hdr_nxt[8], hdr_nxt[9], hdr_nxt[10], hdr_nxt[11]} == 32'h57454250;

    if (jpeg_m) begin
      kind = KIND_JPEG;
    end else if (png_m) begin
      kind = KIND_PNG;
    end else if (tiff_m) begin
      kind = KIND_TIFF;
    end else if (heif_m) begin
      kind = KIND_HEIF;
    end else if (webp_m) begin
      kind = KIND_WEBP;
    end else if (pdf_seen_nxt) begin
      kind = KIND_PDF;
    end else begin
      kind = KIND_UNKNOWN;
    end

    ls_w   = SW'(kw_start_nxt);
    n_s    = SW'(pos_nxt);
    lo_sum = ls_w + SW'(8);
    hi_sum = ls_w + SW'(tail_win_r);
    enc    = (kind == KIND_PDF) && kw_seen_nxt && (lo_sum <= n_s) && (hi_sum >= n_s);

    n_c   = CW'(pos_nxt);
    count = (n_c > CW'({COUNT_BITS{1'b1}})) ? '1 : n_c[COUNT_BITS-1:0];

    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdf_win_r   <= PDF_WIN_RESET;
      tail_win_r  <= TAIL_WIN_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      pdf_prog_r  <= 3'd0;
      pdf_seen_r  <= 1'b0;
      kw_prog_r   <= 3'd0;
      kw_seen_r   <= 1'b0;
      kw_start_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_PDF_SEARCH_WINDOW:   pdf_win_r  <= cfg_wdata[PDF_WIN_BITS-1:0];
          REG_ENCRYPT_TAIL_WINDOW: tail_win_r <= cfg_wdata[TAIL_WIN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        if (s1_last_r) begin
          pos_r      <= '0;
          pdf_prog_r <= 3'd0;
          pdf_seen_r <= 1'b0;
          kw_prog_r  <= 3'd0;
          kw_seen_r  <= 1'b0;
          kw_start_r <= '0;
        end else begin
          pos_r      <= pos_nxt;
          pdf_prog_r <= pdf_prog_nxt;
          pdf_seen_r <= pdf_seen_nxt;
          kw_prog_r  <= kw_prog_nxt;
          kw_seen_r  <= kw_seen_nxt;
          kw_start_r <= kw_start_nxt;
        end
      end
    end
  end

  // The header bytes past the current count are never compared, so they need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[7:0];
      s1_last_r <= in_tlast;
    end
    if (s1_go) begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
    if (s1_go && s1_last_r) begin
      out_data_r <= {(OUT_TDATA_BITS - COUNT_BITS - 4)'(0), count, enc, kind};
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the file signature classifier: stream drive, prediction, checks.
module tb_top
  import fsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_REPORTS   = 10;

  localparam longint unsigned POS_MAX = (64'd1 << DEF_POSITION_BITS) - 1;

  localparam bit [63:0] SIG_JPEG    = 64'hFFD8FF;
  localparam bit [63:0] SIG_PNG     = 64'h89504E470D0A1A0A;
  localparam bit [63:0] SIG_TIFF_LE = 64'h49492A00;
  localparam bit [63:0] SIG_TIFF_BE = 64'h4D4D002A;
  localparam bit [63:0] SIG_FTYP    = "ftyp";
  localparam bit [63:0] SIG_RIFF    = "RIFF";
  localparam bit [63:0] SIG_WEBP    = "WEBP";
  localparam bit [63:0] PDF_WORD    = "%PDF-";
  localparam bit [63:0] ENC_WORD    = "/Encrypt";

  typedef bit [7:0] octet_q_t[$];

  typedef struct {
    bit                       is_cfg;
    bit [7:0]                 data;
    bit                       last;
    logic [CFG_ADDR_BITS-1:0] addr;
    bit [CFG_DATA_BITS-1:0]   value;
  } stream_entry_t;

  typedef struct {
    fsc_kind_t kind;
    bit        encrypted;
    bit [31:0] length;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_BITS-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  file_signature_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1ns clk = ~clk;

  stream_entry_t byte_stream[$];
  verdict_t      awaited_verdicts[$];

  bit [15:0]       pdf_win;
  bit [19:0]       tail_win;
  bit [7:0]        head_bytes[HDR_DEPTH];
  longint unsigned byte_pos;
  int unsigned     pdf_match;
  bit              pdf_found;
  int unsigned     kw_match;
  bit              kw_found;
  longint unsigned kw_start;

  int errors = 0;
  int cycles = 0;
  int bytes_taken = 0;
  int files_checked = 0;
  int encrypted_seen = 0;
  int cfg_writes = 0;
  int kind_tally[8];

  bit in_fire = 1'b0;
  bit stim_done = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  function automatic bit [63:0] brand_code(input int i);
    case (i)
      0:       return "heic";
      1:       return "heix";
      2:       return "heim";
      3:       return "heis";
      4:       return "hevc";
      5:       return "hevm";
      6:       return "hevs";
      7:       return "mif1";
      8:       return "msf1";
      9:       return "avif";
      default: return "avis";
    endcase
  endfunction

  function automatic bit head_match(input longint unsigned n, input int off,
                                    input bit [63:0] sig, input int len);
    if (n < longint'(off + len)) return 1'b0;
    for (int i = 0; i < len; i++)
      if (head_bytes[off+i] != sig[8*(len-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic fsc_kind_t classify_head(input longint unsigned n);
    bit brand_hit;
    brand_hit = 1'b0;
    for (int i = 0; i < 11; i++)
      if (head_match(n, 8, brand_code(i), 4)) brand_hit = 1'b1;
    if (head_match(n, 0, SIG_JPEG, 3)) return KIND_JPEG;
    if (head_match(n, 0, SIG_PNG, 8)) return KIND_PNG;
    if (head_match(n, 0, SIG_TIFF_LE, 4) || head_match(n, 0, SIG_TIFF_BE, 4)) return KIND_TIFF;
    if (head_match(n, 4, SIG_FTYP, 4) && brand_hit) return KIND_HEIF;
    if (head_match(n, 0, SIG_RIFF, 4) && head_match(n, 8, SIG_WEBP, 4)) return KIND_WEBP;
    if (pdf_found) return KIND_PDF;
    return KIND_UNKNOWN;
  endfunction

  task automatic clear_file_scan();
    foreach (head_bytes[i]) head_bytes[i] = 8'h00;
    byte_pos = 0;
    pdf_match = 0;
    pdf_found = 1'b0;
    kw_match = 0;
    kw_found = 1'b0;
    kw_start = 0;
  endtask

  task automatic scan_file_byte(input bit [7:0] b, input bit last);
    longint unsigned idx, n;
    fsc_kind_t kind;
    bit enc;
    bit [31:0] len32;
    idx = byte_pos;
    n = (byte_pos < POS_MAX) ? byte_pos + 1 : POS_MAX;
    if (idx < HDR_DEPTH) head_bytes[idx] = b;

    if (pdf_match < 5 && b == PDF_WORD[8*(4-pdf_match) +: 8]) begin
      pdf_match++;
      if (pdf_match == 5) begin
        if (n <= pdf_win || n == 5) pdf_found = 1'b1;
        pdf_match = 0;
      end
    end else begin
      pdf_match = (b == "%") ? 1 : 0;
    end

    if (b == ENC_WORD[8*(7-kw_match) +: 8]) begin
      if (kw_match == 7) begin
        kw_found = 1'b1;
        kw_start = (idx >= 7) ? idx - 7 : 0;
        kw_match = 0;
      end else begin
        kw_match++;
      end
    end else begin
      kw_match = (b == "/") ? 1 : 0;
    end

    byte_pos = n;
    if (last) begin
      kind = classify_head(n);
      enc = (kind == KIND_PDF) && kw_found && (kw_start + 8 <= n) &&
            (kw_start + tail_win >= n);
      len32 = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n);
      awaited_verdicts.insert(awaited_verdicts.size(),
                              '{kind: kind, encrypted: enc, length: len32});
      clear_file_scan();
    end
  endtask

  task automatic report_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("tb_top: cycle %0d: %s", cycles, what);
  endtask

  task automatic put_sig(ref octet_q_t body, input int off, input bit [127:0] sig,
                         input int len);
    for (int i = 0; i < len; i++)
      if (off + i >= 0 && off + i < body.size()) body[off+i] = sig[8*(len-1-i) +: 8];
  endtask

  function automatic octet_q_t sig_file(input bit [127:0] sig, input int len);
    octet_q_t body;
    for (int i = 0; i < len; i++) body.insert(body.size(), sig[8*(len-1-i) +: 8]);
    return body;
  endfunction

  task automatic push_file(input octet_q_t body);
    foreach (body[i])
      byte_stream.insert(byte_stream.size(),
                         '{is_cfg: 1'b0, data: body[i], last: (i == body.size() - 1),
                           addr: '0, value: '0});
  endtask

  task automatic push_cfg(input logic [CFG_ADDR_BITS-1:0] addr,
                          input bit [CFG_DATA_BITS-1:0] value);
    byte_stream.insert(byte_stream.size(),
                       '{is_cfg: 1'b1, data: 8'h00, last: 1'b0, addr: addr, value: value});
  endtask

  // Mostly well-formed signatures over random fill; short lengths truncate them.
  task automatic push_random_files(input int budget);
    octet_q_t body;
    int added, len, pick, off, span;
    added = 0;
    while (added < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 100) : $urandom_range(1, 32);
      body = {};
      repeat (len) body.insert(body.size(), 8'($urandom));
      pick = $urandom_range(0, 9);
      case (pick)
        0: put_sig(body, 0, SIG_JPEG, 3);
        1: put_sig(body, 0, SIG_PNG, 8);
        2: put_sig(body, 0, SIG_TIFF_LE, 4);
        3: put_sig(body, 0, SIG_TIFF_BE, 4);
        4: begin
          put_sig(body, 4, SIG_FTYP, 4);
          put_sig(body, 8, brand_code($urandom_range(0, 10)), 4);
        end
        5: begin
          put_sig(body, 0, SIG_RIFF, 4);
          put_sig(body, 8, SIG_WEBP, 4);
        end
        6, 7: begin
          off = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, len);
          put_sig(body, off, PDF_WORD, 5);
          if ($urandom_range(0, 3) == 0) put_sig(body, off - 1, "%", 1);
          if ($urandom_range(0, 5) == 0) put_sig(body, 0, SIG_JPEG, 3);
        end
        default: ;
      endcase
      if (pick < 8 && $urandom_range(0, 4) == 0) begin
        span = (len < HDR_DEPTH) ? len : HDR_DEPTH;
        off = $urandom_range(0, span - 1);
        body[off] = body[off] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 9) < ((pick == 6 || pick == 7) ? 6 : 2)) begin
        off = $urandom_range(0, len);
        put_sig(body, off, ENC_WORD, 8);
        case ($urandom_range(0, 4))
          0: put_sig(body, off - 1, "/", 1);
          1: put_sig(body, off + 7, "x", 1);
          2: put_sig(body, $urandom_range(0, len), ENC_WORD, 8);
          default: ;
        endcase
      end
      push_file(body);
      added += len;
    end
  endtask

  // Predictor, checker and handshake sampling.
  always @(posedge clk) begin
    verdict_t want;
    in_fire <= in_tvalid && in_tready;
    if (!rst_n) begin
      pdf_win = PDF_WIN_RESET;
      tail_win = TAIL_WIN_RESET;
      clear_file_scan();
    end else begin
      if (cfg_wr_en) begin
        cfg_writes++;
        if (cfg_addr == REG_PDF_SEARCH_WINDOW) pdf_win = cfg_wdata[15:0];
        else if (cfg_addr == REG_ENCRYPT_TAIL_WINDOW) tail_win = cfg_wdata[19:0];
      end
      if (out_tvalid && out_tready) begin
        if (awaited_verdicts.size() == 0) begin
          report_error($sformatf("unexpected result kind %0d enc %0d count %0d",
                                 out_tdata[2:0], out_tdata[3], out_tdata[35:4]));
        end else begin
          want = awaited_verdicts.pop_front();
          files_checked++;
          kind_tally[want.kind]++;
          if (want.encrypted) encrypted_seen++;
          if (out_tdata[2:0] != want.kind || out_tdata[3] != want.encrypted ||
              out_tdata[35:4] != want.length)
            report_error($sformatf(
              "mismatch: expected kind %0d enc %0d count %0d, got kind %0d enc %0d count %0d",
              want.kind, want.encrypted, want.length,
              out_tdata[2:0], out_tdata[3], out_tdata[35:4]));
        end
      end
      if (in_tvalid && in_tready) begin
        bytes_taken++;
        scan_file_byte(in_tdata, in_tlast);
      end
    end
  end

  // Byte driver with bursts and gaps; register writes wait until the block is idle.
  always @(negedge clk) begin
    stream_entry_t item;
    bit nv, nl, ncfg;
    bit [7:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    nl = in_tlast;
    ncfg = 1'b0;
    if (in_tvalid && in_fire) nv = 1'b0;
    if (in_tvalid || awaited_verdicts.size() != 0) quiet_cycles = 0;
    else quiet_cycles++;
    if (!nv && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_stream.size() != 0) begin
        if (byte_stream[0].is_cfg) begin
          if (!in_tvalid && !cfg_wr_en && quiet_cycles >= SETTLE_CYCLES) begin
            item = byte_stream.pop_front();
            ncfg = 1'b1;
            cfg_addr <= item.addr;
            cfg_wdata <= item.value;
          end
        end else begin
          item = byte_stream.pop_front();
          nv = 1'b1;
          nd = item.data;
          nl = item.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 6);
          end
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
    in_tlast <= nl;
    cfg_wr_en <= ncfg;
    stim_done <= rst_n && !nv && byte_stream.size() == 0 && awaited_verdicts.size() == 0;
  end

  // Result receiver: out_tready follows one of five randomly chosen stall patterns.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 4);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      3:       out_tready <= (rx_tick % 16 < 5);
      default: out_tready <= (rx_tick % 32 >= 20);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    // Directed files under the reset windows.
    push_file(sig_file(8'hFF, 1));
    push_file(sig_file(16'hFFD8, 2));
    push_file(sig_file(SIG_JPEG, 3));
    push_file(sig_file(SIG_TIFF_BE, 4));
    push_file(sig_file("%PDF-/Encrypt", 13));
    push_random_files(200);

    push_cfg(REG_PDF_SEARCH_WINDOW, 20'd5);
    push_cfg(REG_ENCRYPT_TAIL_WINDOW, 20'd8);
    push_random_files(200);

    // Windows below the nominal range.
    push_cfg(REG_PDF_SEARCH_WINDOW, 20'd0);
    push_cfg(REG_ENCRYPT_TAIL_WINDOW, 20'd0);
    push_file(sig_file("%PDF-/Encrypt", 13));
    push_random_files(150);
    push_cfg(REG_PDF_SEARCH_WINDOW, 20'd3);
    push_cfg(REG_ENCRYPT_TAIL_WINDOW, 20'd7);
    push_random_files(150);

    push_cfg(REG_PDF_SEARCH_WINDOW, 20'd65535);
    push_cfg(REG_ENCRYPT_TAIL_WINDOW, 20'hFFFFF);
    push_random_files(200);

    repeat (3) begin
      push_cfg(REG_PDF_SEARCH_WINDOW, 20'($urandom_range(5, 40)));
      push_cfg(REG_ENCRYPT_TAIL_WINDOW, 20'($urandom_range(8, 48)));
      push_random_files(170);
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (!stim_done) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_verdicts.size() != 0)
      report_error($sformatf("%0d results never arrived", awaited_verdicts.size()));

    $display("tb_top: %0d files, %0d bytes, %0d register writes, %0d encrypted PDFs",
             files_checked, bytes_taken, cfg_writes, encrypted_seen);
    $display("tb_top: kinds unknown %0d pdf %0d jpeg %0d png %0d tiff %0d heif %0d webp %0d",
             kind_tally[KIND_UNKNOWN], kind_tally[KIND_PDF], kind_tally[KIND_JPEG],
             kind_tally[KIND_PNG], kind_tally[KIND_TIFF], kind_tally[KIND_HEIF],
             kind_tally[KIND_WEBP]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
